>>> hw/rtl/health_monitor_backoff_macros.svh
// assertion macros shared by the health monitor rtl
// no dependencies
`ifndef HEALTH_MONITOR_BACKOFF_MACROS_SVH
`define HEALTH_MONITOR_BACKOFF_MACROS_SVH

// same-cycle implication, disabled during reset
`define HMB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("health monitor: implication check failed");

// next-cycle implication, disabled during reset
`define HMB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("health monitor: next-cycle check failed");

`endif

>>> hw/rtl/hmb_pkg.sv
// types, codes and constants for the health monitor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hmb_pkg;

    localparam int MULT_W  = 14;
    localparam int LAT_W   = 32;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 16;
    localparam int ERR_W   = 5;
    localparam int LIMIT_W = 4;
    localparam int KIND_W  = 3;
    localparam int NUM_W   = LAT_W + CNT_W + 1;
    localparam int DEN_W   = CNT_W + 1;
    localparam int QUO_W   = LAT_W;
    localparam int STEP_W  = $clog2(QUO_W);

    localparam int IN_W    = 72;
    localparam int OUT_W   = 88;
    localparam int CFG_A_W = 3;

    localparam logic [MULT_W-1:0] MULT_ONE = MULT_W'(256);
    localparam logic [MULT_W-1:0] MULT_TWO = MULT_W'(512);
    localparam logic [MULT_W-1:0] MULT_SAT = {MULT_W{1'b1}};
    localparam logic [ERR_W-1:0]  ERR_SAT  = ERR_W'(16);
    localparam logic [CNT_W-1:0]  CHECK_SAT = {CNT_W{1'b1}};

    // reply kinds
    localparam logic [KIND_W-1:0] KIND_NOERROR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NXDOMAIN = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NOREC    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SERVFAIL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REFUSED  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SENDFAIL = 3'd7;
    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd7;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_MIN_MULT     = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_MAX_MULT     = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_OFFLINE_MULT = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_INITIAL_MULT = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_ERROR_LIMIT  = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_EXPECTED     = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_CHECK_ADDR   = 3'd6;

    typedef enum logic [1:0] {
        STAT_NONE    = 2'd0,
        STAT_OFFLINE = 2'd1,
        STAT_ONLINE  = 2'd2
    } hmb_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } hmb_state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } hmb_div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } hmb_div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/hmb_div.sv
// restoring divider, one quotient bit per cycle
// depends on hmb_pkg; quotient must fit in QUO_W bits
`timescale 1ns / 1ps
`default_nettype none

module hmb_div
    import hmb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire hmb_div_req_t req,
    output hmb_div_rsp_t      rsp
);

    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [QUO_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    shifted;
    logic              ge;

    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb
    begin
        if (ge)
        begin
            rem_next = DEN_W'(shifted - {1'b0, den_reg});
        end
        else
        begin
            rem_next = shifted[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // high dividend bits start as remainder, low bits shift out as quotient shifts in
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num[NUM_W-1:QUO_W];
            quo_reg <= req.num[QUO_W-1:0];
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

>>> hw/rtl/health_monitor_backoff.sv
// health monitor with exponential probe interval back-off, top level
// depends on hmb_pkg, hmb_div and health_monitor_backoff_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "health_monitor_backoff_macros.svh"

// Each accepted request is one probe outcome; it yields exactly one result.
// The block takes one request at a time: s_tready is high only while idle.
// A request that does not update the running mean latency (any error, or a
// success that brings the target back online) goes from accept to ST_DONE;
// a success while alive passes ST_MUL, ST_LOAD and ST_DIV first, where one
// 32x16 multiply and the 32-step serial divider form the new mean. The
// result sits in an output register, so a new request is accepted while it
// waits to be taken. Configuration writes are applied at once, index 7 is
// ignored; initial_mult reloads the multiplier unless a request is accepted.

module health_monitor_backoff
    import hmb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // reply_kind[2:0], address_readable[3], address_blocked[4],
    // probe_latency[36:5], now_time[68:37], zero[71:69]
    input  wire logic [IN_W-1:0]    s_tdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // alive[0], status_change[2:1], next_mult[16:3], mean_latency[48:17],
    // total_downtime[80:49], error_count[85:81], zero[87:86]
    output logic [OUT_W-1:0]        m_tdata,
    input  wire logic               cfg_we,
    input  wire logic [CFG_A_W-1:0] cfg_addr,
    input  wire logic [MULT_W-1:0]  cfg_wdata
);

    // input fields
    logic [KIND_W-1:0] reply_kind;
    logic              address_readable;
    logic              address_blocked;
    logic [LAT_W-1:0]  probe_latency;
    logic [TIME_W-1:0] now_time;

    assign reply_kind       = s_tdata[2:0];
    assign address_readable = s_tdata[3];
    assign address_blocked  = s_tdata[4];
    assign probe_latency    = s_tdata[36:5];
    assign now_time         = s_tdata[68:37];

    // configuration
    logic [MULT_W-1:0]  min_mult_reg;
    logic [MULT_W-1:0]  max_mult_reg;
    logic [MULT_W-1:0]  offline_mult_reg;
    logic [LIMIT_W-1:0] error_limit_reg;
    logic [KIND_W-1:0]  expected_reg;
    logic               check_addr_reg;

    // monitor state
    logic               alive_reg;
    logic               alive_next;
    logic [ERR_W-1:0]   err_count_reg;
    logic [ERR_W-1:0]   err_count_next;
    logic [MULT_W-1:0]  mult_reg;
    logic [MULT_W-1:0]  mult_next;
    logic [LAT_W-1:0]   lat_mean_reg;
    logic [CNT_W-1:0]   check_count_reg;
    logic [CNT_W-1:0]   check_count_next;
    logic [TIME_W-1:0]  since_reg;
    logic [TIME_W-1:0]  since_next;
    logic [TIME_W-1:0]  down_reg;
    logic [TIME_W-1:0]  down_next;
    hmb_status_t        status_reg;
    hmb_status_t        status_next;
    logic               mean_load;
    logic               need_div;

    // mean update datapath
    logic [LAT_W-1:0]       lat_reg;
    logic [CNT_W-1:0]       n_reg;
    logic [LAT_W+CNT_W-1:0] prod_reg;

    hmb_state_t   state_reg;
    hmb_state_t   state_next;
    logic         accept;
    logic         out_free;
    logic         m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    hmb_div_req_t div_req;
    hmb_div_rsp_t div_rsp;

    // classification and state update
    logic [ERR_W-1:0]  err_pre;
    logic              ok;
    logic [MULT_W:0]   mult_dbl;
    logic [MULT_W-1:0] mult_dbl_sat;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign mult_dbl = {mult_reg, 1'b0};
    assign mult_dbl_sat = (mult_dbl > {1'b0, MULT_SAT}) ? MULT_SAT : mult_dbl[MULT_W-1:0];

    always_comb
    begin
        err_pre = err_count_reg;
        if ((reply_kind == KIND_SENDFAIL) && (err_count_reg < ERR_SAT))
        begin
            err_pre = err_count_reg + 1'b1;
        end

        priority if (reply_kind == KIND_SENDFAIL)
        begin
            ok = 1'b0;
        end
        else if ((reply_kind == KIND_SERVFAIL) || (reply_kind == KIND_REFUSED) ||
                 (reply_kind == KIND_TIMEOUT))
        begin
            ok = 1'b0;
        end
        else if (expected_reg != KIND_NONE)
        begin
            ok = (reply_kind == expected_reg) ||
                 ((reply_kind == KIND_NOREC) && (expected_reg == KIND_NXDOMAIN));
        end
        else if (check_addr_reg)
        begin
            ok = (reply_kind == KIND_NOERROR) && address_readable && !address_blocked;
        end
        else
        begin
            ok = 1'b1;
        end

        alive_next       = alive_reg;
        err_count_next   = err_pre;
        mult_next        = mult_reg;
        check_count_next = check_count_reg;
        since_next       = since_reg;
        down_next        = down_reg;
        status_next      = STAT_NONE;
        mean_load        = 1'b0;
        need_div         = 1'b0;

        if (ok)
        begin
            err_count_next = '0;
            if (!alive_reg)
            begin
                mult_next        = MULT_ONE;
                down_next        = down_reg + (now_time - since_reg);
                since_next       = '0;
                check_count_next = CNT_W'(1);
                mean_load        = 1'b1;
                alive_next       = 1'b1;
                status_next      = STAT_ONLINE;
            end
            else
            begin
                if (mult_reg < max_mult_reg)
                begin
                    mult_next = (mult_reg < MULT_ONE) ? MULT_ONE : mult_dbl_sat;
                end
                else
                begin
                    mult_next = max_mult_reg;
                end
                if (check_count_reg < CHECK_SAT)
                begin
                    check_count_next = check_count_reg + 1'b1;
                end
                need_div = 1'b1;
            end
        end
        else if (alive_reg)
        begin
            if (err_pre < {1'b0, error_limit_reg})
            begin
                err_count_next = err_pre + 1'b1;
                if (mult_reg > min_mult_reg)
                begin
                    mult_next = (mult_reg < MULT_ONE) ? MULT_ONE : (mult_reg >> 1);
                end
            end
            else
            begin
                alive_next  = 1'b0;
                since_next  = now_time;
                mult_next   = MULT_TWO;
                status_next = STAT_OFFLINE;
            end
        end
        else
        begin
            mult_next = (mult_reg < offline_mult_reg) ? mult_dbl_sat : offline_mult_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mult_reg     <= MULT_W'(26);
            max_mult_reg     <= MULT_W'(8192);
            offline_mult_reg <= MULT_W'(2048);
            error_limit_reg  <= LIMIT_W'(2);
            expected_reg     <= KIND_NONE;
            check_addr_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MIN_MULT:     min_mult_reg     <= cfg_wdata;
                REG_MAX_MULT:     max_mult_reg     <= cfg_wdata;
                REG_OFFLINE_MULT: offline_mult_reg <= cfg_wdata;
                REG_ERROR_LIMIT:  error_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                REG_EXPECTED:     expected_reg     <= cfg_wdata[KIND_W-1:0];
                REG_CHECK_ADDR:   check_addr_reg   <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg       <= 1'b1;
            err_count_reg   <= '0;
            mult_reg        <= MULT_W'(26);
            lat_mean_reg    <= '0;
            check_count_reg <= '0;
            since_reg       <= '0;
            down_reg        <= '0;
            status_reg      <= STAT_NONE;
        end
        else
        begin
            if (accept)
            begin
                alive_reg       <= alive_next;
                err_count_reg   <= err_count_next;
                mult_reg        <= mult_next;
                check_count_reg <= check_count_next;
                since_reg       <= since_next;
                down_reg        <= down_next;
                status_reg      <= status_next;
                if (mean_load)
                begin
                    lat_mean_reg <= probe_latency;
                end
            end
            else if (cfg_we && (cfg_addr == REG_INITIAL_MULT))
            begin
                mult_reg <= cfg_wdata;
            end
            if (div_rsp.done)
            begin
                lat_mean_reg <= div_rsp.quo;
            end
        end
    end

    // mean = (lat + mean * n) / (n + 1)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lat_reg <= probe_latency;
            n_reg   <= check_count_reg;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= lat_mean_reg * n_reg;
        end
    end

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = {1'b0, prod_reg} + {{(NUM_W-LAT_W){1'b0}}, lat_reg};
        div_req.den   = {1'b0, n_reg} + 1'b1;
        state_next    = state_reg;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = need_div ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            m_tdata_reg <= {2'b00, err_count_reg, down_reg, lat_mean_reg, mult_reg,
                            status_reg, alive_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    hmb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    `HMB_ASSERT_IMP(a_err_range, clk, rst_n, 1'b1, err_count_reg <= ERR_SAT)
    `HMB_ASSERT_IMP(a_div_done_state, clk, rst_n, div_rsp.done, state_reg == ST_DIV)
    `HMB_ASSERT_NXT(a_accept_next, clk, rst_n, accept,
        (state_reg == ST_MUL) || (state_reg == ST_DONE))
    `HMB_ASSERT_IMP(a_online_clears_err, clk, rst_n, $rose(alive_reg),
        (err_count_reg == '0) && (status_reg == STAT_ONLINE))

endmodule

`default_nettype wire
